FILE: hdl/svc_pkg.sv
// Shared types and constants for the snapshot visibility check.
package svc_pkg;

	localparam int TXID_W          = 64;
	localparam int ID_W            = 63;
	localparam int OP_W            = 2;
	localparam int CFG_INDEX_W     = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int STORED_COUNT_W  = 8;
	localparam int MAX_IN_PROGRESS = 128;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH = 8'd1;

	typedef enum logic [1:0] {
		CLS_CLEAR,
		CLS_ADD,
		CLS_DECIDED,
		CLS_SCAN
	} cls_t;

	typedef struct packed {
		cls_t            cls;
		logic            vis;
		logic [ID_W-1:0] id;
	} item_t;

	typedef enum logic {
		BK_IDLE,
		BK_SCAN
	} bk_state_t;

endpackage

FILE: hdl/svc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/svc_queue.sv
// Short item queue between the front and back parts.
module svc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  svc_pkg::item_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output svc_pkg::item_t head
);

	svc_pkg::item_t                      slot_q [svc_pkg::QUEUE_DEPTH];
	logic [svc_pkg::QUEUE_PTR_W-1:0]     wptr_q;
	logic [svc_pkg::QUEUE_PTR_W-1:0]     rptr_q;
	logic [svc_pkg::QUEUE_CNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == svc_pkg::QUEUE_CNT_W'(svc_pkg::QUEUE_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == svc_pkg::QUEUE_PTR_W'(svc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == svc_pkg::QUEUE_PTR_W'(svc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/svc_front.sv
// Front part: window registers, item intake and classification.
module svc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [svc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [svc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [svc_pkg::OP_W-1:0]          op,
	input  logic [svc_pkg::TXID_W-1:0]        txid_value,
	input  logic                              q_full,
	output logic                              push,
	output svc_pkg::item_t                    push_item
);

	logic [svc_pkg::ID_W-1:0] window_low_q;
	logic [svc_pkg::ID_W-1:0] window_high_q;
	logic                     below_low;
	logic                     at_or_above_high;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= '0;
			window_high_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == svc_pkg::REG_WINDOW_LOW) begin
				window_low_q <= cfg_data[svc_pkg::ID_W-1:0];
			end else if (cfg_index == svc_pkg::REG_WINDOW_HIGH) begin
				window_high_q <= cfg_data[svc_pkg::ID_W-1:0];
			end
		end
	end

	assign below_low        = txid_value < {1'b0, window_low_q};
	assign at_or_above_high = txid_value >= {1'b0, window_high_q};

	always_comb begin
		push_item.id  = txid_value[svc_pkg::ID_W-1:0];
		push_item.vis = 1'b0;
		case (op)
			svc_pkg::OP_CLEAR: begin
				push_item.cls = svc_pkg::CLS_CLEAR;
			end
			svc_pkg::OP_ADD: begin
				push_item.cls = svc_pkg::CLS_ADD;
			end
			svc_pkg::OP_QUERY: begin
				if (below_low) begin
					push_item.cls = svc_pkg::CLS_DECIDED;
					push_item.vis = 1'b1;
				end else if (at_or_above_high) begin
					push_item.cls = svc_pkg::CLS_DECIDED;
				end else begin
					push_item.cls = svc_pkg::CLS_SCAN;
				end
			end
			default: begin
				push_item.cls = svc_pkg::CLS_DECIDED;
			end
		endcase
	end

endmodule

FILE: hdl/svc_back.sv
// Back part: id list, list scan sequencer and result register.
module svc_back #(
	parameter int MAX_IN_PROGRESS = svc_pkg::MAX_IN_PROGRESS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_avail,
	input  svc_pkg::item_t                       q_head,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 visible,
	output logic                                 accepted,
	output logic [svc_pkg::STORED_COUNT_W-1:0]   stored_count
);

	localparam int AW = (MAX_IN_PROGRESS > 1) ? $clog2(MAX_IN_PROGRESS) : 1;
	localparam int CW = $clog2(MAX_IN_PROGRESS + 1);

	svc_pkg::bk_state_t       state_q;
	svc_pkg::bk_state_t       state_d;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic [CW-1:0]            scan_q;
	logic                     pend_s1;
	logic                     hit_q;
	logic [svc_pkg::ID_W-1:0] id_q;
	logic                     out_valid_q;
	logic                     out_vis_q;
	logic                     out_acc_q;
	logic [svc_pkg::STORED_COUNT_W-1:0] out_cnt_q;

	logic                     out_free;
	logic                     start_scan;
	logic                     finish;
	logic                     load;
	logic                     ld_vis;
	logic                     ld_acc;
	logic                     mem_we;
	logic                     rd_en;
	logic [svc_pkg::ID_W-1:0] rdata;
	logic [CW+svc_pkg::STORED_COUNT_W-1:0] count_ext;

	assign out_free  = !out_valid_q || !out_stall;
	assign count_ext = {{svc_pkg::STORED_COUNT_W{1'b0}}, count_d};

	svc_ram #(
		.WIDTH(svc_pkg::ID_W),
		.DEPTH(MAX_IN_PROGRESS)
	) u_ids (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(q_head.id),
		.re   (rd_en),
		.raddr(scan_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			svc_pkg::BK_IDLE: begin
				if (start_scan) begin
					state_d = svc_pkg::BK_SCAN;
				end
			end
			svc_pkg::BK_SCAN: begin
				if (finish) begin
					state_d = svc_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = svc_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		start_scan = 1'b0;
		finish     = 1'b0;
		load       = 1'b0;
		ld_vis     = 1'b0;
		ld_acc     = 1'b1;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		count_d    = count_q;
		case (state_q)
			svc_pkg::BK_IDLE: begin
				if (q_avail && out_free) begin
					q_pop = 1'b1;
					case (q_head.cls)
						svc_pkg::CLS_CLEAR: begin
							load    = 1'b1;
							count_d = '0;
						end
						svc_pkg::CLS_ADD: begin
							load = 1'b1;
							if (count_q == CW'(MAX_IN_PROGRESS)) begin
								ld_acc = 1'b0;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						svc_pkg::CLS_DECIDED: begin
							load   = 1'b1;
							ld_vis = q_head.vis;
						end
						svc_pkg::CLS_SCAN: begin
							start_scan = 1'b1;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			svc_pkg::BK_SCAN: begin
				rd_en = (scan_q != count_q);
				if (scan_q == count_q && !pend_s1 && out_free) begin
					finish = 1'b1;
					load   = 1'b1;
					ld_vis = !hit_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			id_q <= q_head.id;
		end
		if (load) begin
			out_vis_q <= ld_vis;
			out_acc_q <= ld_acc;
			out_cnt_q <= count_ext[svc_pkg::STORED_COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svc_pkg::BK_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= rd_en;
			if (start_scan) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					scan_q <= scan_q + 1'b1;
				end
				if (pend_s1 && rdata == id_q) begin
					hit_q <= 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign visible      = out_vis_q;
	assign accepted     = out_acc_q;
	assign stored_count = out_cnt_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_IN_PROGRESS))
		else $error("id count above list capacity");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svc_pkg::BK_SCAN |-> scan_q <= count_q)
		else $error("scan address ran past the id count");
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == svc_pkg::BK_SCAN |-> !mem_we && !q_pop)
		else $error("list written or item taken during scan");
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == svc_pkg::BK_SCAN)
		else $error("read data pending outside scan");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result overwrote a stalled item");
`endif

endmodule

FILE: hdl/snapshot_visibility_check_core.sv
// Top level of the snapshot visibility check: front, queue and back parts.
// Clear, add and window-decided queries pass from accept through a queue slot into the
// result register. Throughput: one such item per cycle while the output is not stalled;
// a query inside the window holds the back part while it scans the id list, one list
// entry read per cycle. Reset clears the window registers, the id count and all
// handshake state; the id RAM is not cleared.
module snapshot_visibility_check_core #(
	parameter int MAX_IN_PROGRESS = svc_pkg::MAX_IN_PROGRESS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [svc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [svc_pkg::OP_W-1:0]             op,
	input  logic [svc_pkg::TXID_W-1:0]           txid_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 visible,
	output logic                                 accepted,
	output logic [svc_pkg::STORED_COUNT_W-1:0]   stored_count
);

	logic           q_full;
	logic           q_push;
	svc_pkg::item_t q_push_item;
	logic           q_pop;
	logic           q_avail;
	svc_pkg::item_t q_head;

	svc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.txid_value(txid_value),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	svc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	svc_back #(
		.MAX_IN_PROGRESS(MAX_IN_PROGRESS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_avail     (q_avail),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.visible     (visible),
		.accepted    (accepted),
		.stored_count(stored_count)
	);

endmodule
